### src/rcs_pkg.sv
// rcs_pkg: shared constants, controller/datapath command and status types,
// and field width helpers for the rarest chunk selector
// no dependencies
package rcs_pkg;

    localparam int MAX_CHUNKS  = 64;
    localparam int COUNT_WIDTH = 10;

    // derived widths
    localparam int IDX_W       = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int CHUNK_CNT_W = $clog2(MAX_CHUNKS + 1);
    localparam int RND_W       = 32;
    localparam int RND_CNT_W   = $clog2(RND_W);

    // fixed field widths of the stream and register interfaces
    localparam int BITS_W      = 64;
    localparam int CFG_W       = 7;
    localparam int IDX_OUT_W   = 6;
    localparam int COUNT_OUT_W = 10;
    localparam int TIE_OUT_W   = 7;
    localparam int IN_DATA_W   = BITS_W + RND_W;
    localparam int OUT_DATA_W  = IDX_OUT_W + COUNT_OUT_W + TIE_OUT_W + 1;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    // register map, word index taken from paddr[2]
    localparam logic REG_CHUNKS_IN_USE = 1'b0;
    localparam logic [CFG_W-1:0] CHUNKS_RESET = 7'd64;

    typedef struct packed {
        logic count_row;   // add the accepted row into the counters
        logic start;       // last row accepted, arm the minimum scan
        logic min_step;    // one rotation step of the minimum and tie scan
        logic div_load;    // load the tie-break remainder unit
        logic div_step;    // one bit of the remainder
        logic pick_step;   // one rotation step of the pick scan
        logic emit;        // load the result register and clear the counters
    } rcs_cmd_t;

    typedef struct packed {
        logic idx_last;    // scan position is at the final counter
        logic div_last;    // remainder unit is on its final bit
    } rcs_status_t;

    function automatic logic [IDX_OUT_W-1:0] idx_to_out(input logic [IDX_W-1:0] v);
        logic [IDX_W+IDX_OUT_W-1:0] ext;
        ext = {{IDX_OUT_W{1'b0}}, v};
        return ext[IDX_OUT_W-1:0];
    endfunction

    function automatic logic [COUNT_OUT_W-1:0] count_to_out(
        input logic [COUNT_WIDTH-1:0] v);
        logic [COUNT_WIDTH+COUNT_OUT_W-1:0] ext;
        ext = {{COUNT_OUT_W{1'b0}}, v};
        return ext[COUNT_OUT_W-1:0];
    endfunction

    function automatic logic [TIE_OUT_W-1:0] tie_to_out(input logic [CHUNK_CNT_W-1:0] v);
        logic [CHUNK_CNT_W+TIE_OUT_W-1:0] ext;
        ext = {{TIE_OUT_W{1'b0}}, v};
        return ext[TIE_OUT_W-1:0];
    endfunction

endpackage

### src/rarest_chunk_selector.sv
// rarest_chunk_selector: top level, stream ports, register port, controller
// and datapath; depends on rcs_pkg, rcs_ctrl, rcs_datapath
//
//  port group   direction  payload
//  s_axis       in         tdata: chunk_bits[63:0], random_word[95:64]
//                          tuser: has_peer   tlast: last_peer
//  m_axis       out        tdata: chunk_index, rarest_count, tie_count,
//                          count_saturated
//  apb          in/out     chunks_in_use at byte address 0
//
// a row without tlast updates all counters in parallel
// a row with tlast holds s_axis_tready low through the minimum and tie
//   scan over the rotating counter array, the load and bit-serial remainder
//   of random_word by the tie count, the pick scan and the load of the result
//   register that clears the counters
// the result register waits for m_axis_tready while new rows are taken;
//   a second query stalls only at its final load if the first is still held
// reset clears counters, the saturation flag and the result valid; no
//   clearing pass is needed
module rarest_chunk_selector (
    input  logic                                clk,
    input  logic                                rst_n,
    // input rows
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [rcs_pkg::IN_DATA_W-1:0]       s_axis_tdata,  // chunk_bits, random_word
    input  logic                                s_axis_tuser,  // has_peer
    input  logic                                s_axis_tlast,  // last_peer
    // selection results
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [rcs_pkg::OUT_DATA_W-1:0]      m_axis_tdata,  // chunk_index, rarest_count,
                                                               // tie_count, count_saturated
    // register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rcs_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [rcs_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [rcs_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);
    import rcs_pkg::*;

    rcs_cmd_t               cmd;
    rcs_status_t            status;
    logic [CFG_W-1:0]       chunks_in_use_reg;
    logic                   cfg_write;

    logic [IDX_OUT_W-1:0]   chunk_index;
    logic [COUNT_OUT_W-1:0] rarest_count;
    logic [TIE_OUT_W-1:0]   tie_count;
    logic                   count_saturated;

    // register port: zero wait states, word index from paddr[2]
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == REG_CHUNKS_IN_USE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            chunks_in_use_reg <= CHUNKS_RESET;
        else if (cfg_write)
            chunks_in_use_reg <= pwdata[CFG_W-1:0];
    end

    assign prdata = (paddr[2] == REG_CHUNKS_IN_USE)
                    ? {{(APB_DATA_W-CFG_W){1'b0}}, chunks_in_use_reg}
                    : '0;

    rcs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_last   (s_axis_tlast),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    rcs_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .chunk_bits      (s_axis_tdata[BITS_W-1:0]),
        .has_peer        (s_axis_tuser),
        .random_word     (s_axis_tdata[IN_DATA_W-1:BITS_W]),
        .chunks_in_use   (chunks_in_use_reg),
        .chunk_index     (chunk_index),
        .rarest_count    (rarest_count),
        .tie_count       (tie_count),
        .count_saturated (count_saturated)
    );

    // result fields, chunk_index in the lowest bits, count_saturated on top
    assign m_axis_tdata = {count_saturated, tie_count, rarest_count, chunk_index};

endmodule

### src/rcs_ctrl.sv
// rcs_ctrl: sequencing state machine of the rarest chunk selector
// depends on rcs_pkg
module rcs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_last,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  rcs_pkg::rcs_status_t status,
    output rcs_pkg::rcs_cmd_t   cmd
);
    import rcs_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MIN_SCAN,
        ST_DIV_INIT,
        ST_DIVIDE,
        ST_PICK_SCAN,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.count_row = 1'b1;
                    if (in_last)
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_MIN_SCAN;
                    end
                end
            end
            ST_MIN_SCAN:
            begin
                cmd.min_step = 1'b1;
                if (status.idx_last)
                begin
                    state_next = ST_DIV_INIT;
                end
            end
            ST_DIV_INIT:
            begin
                cmd.div_load = 1'b1;
                state_next   = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_PICK_SCAN;
                end
            end
            ST_PICK_SCAN:
            begin
                cmd.pick_step = 1'b1;
                if (status.idx_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### src/rcs_datapath.sv
// rcs_datapath: occurrence counters, rotating scan, tie-break remainder unit
// and result register of the rarest chunk selector; depends on rcs_pkg
module rcs_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  rcs_pkg::rcs_cmd_t                cmd,
    output rcs_pkg::rcs_status_t             status,
    input  logic [rcs_pkg::BITS_W-1:0]       chunk_bits,
    input  logic                             has_peer,
    input  logic [rcs_pkg::RND_W-1:0]        random_word,
    input  logic [rcs_pkg::CFG_W-1:0]        chunks_in_use,
    output logic [rcs_pkg::IDX_OUT_W-1:0]    chunk_index,
    output logic [rcs_pkg::COUNT_OUT_W-1:0]  rarest_count,
    output logic [rcs_pkg::TIE_OUT_W-1:0]    tie_count,
    output logic                             count_saturated
);
    import rcs_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    logic [COUNT_WIDTH-1:0] cnt_reg [MAX_CHUNKS];
    logic [COUNT_WIDTH-1:0] cnt_next [MAX_CHUNKS];
    logic                   sat_reg, sat_next;

    logic [IDX_W-1:0]       idx_reg;
    logic [COUNT_WIDTH-1:0] min_reg;
    logic [CHUNK_CNT_W-1:0] ties_reg;
    logic [RND_W-1:0]       rnd_reg;
    logic [CHUNK_CNT_W-1:0] rem_reg;
    logic [RND_CNT_W-1:0]   bit_cnt_reg;
    logic [CHUNK_CNT_W-1:0] seen_reg;
    logic                   found_reg;
    logic [IDX_W-1:0]       sel_reg;

    logic [IDX_OUT_W-1:0]   chunk_index_reg;
    logic [COUNT_OUT_W-1:0] rarest_count_reg;
    logic [TIE_OUT_W-1:0]   tie_count_reg;
    logic                   count_saturated_reg;

    logic [CFG_W-1:0]       n_wide;
    logic [CHUNK_CNT_W-1:0] n_active;
    logic                   head_active;
    logic                   head_is_min;
    logic [CHUNK_CNT_W:0]   trial;

    // chunk count zero reads as one, above the counter array clamps
    always_comb
    begin
        priority if (chunks_in_use == '0)
            n_wide = CFG_W'(1);
        else if (chunks_in_use > CFG_W'(MAX_CHUNKS))
            n_wide = CFG_W'(MAX_CHUNKS);
        else
            n_wide = chunks_in_use;
    end
    assign n_active = n_wide[CHUNK_CNT_W-1:0];

    // the scan always looks at counter 0, the array rotates under it
    assign head_active = CHUNK_CNT_W'(idx_reg) < n_active;
    assign head_is_min = head_active && (cnt_reg[0] == min_reg);

    assign status = '{idx_last: (idx_reg == IDX_W'(MAX_CHUNKS - 1)),
                      div_last: (bit_cnt_reg == '0)};

    // restoring remainder step, one bit of random_word per cycle
    assign trial = {rem_reg, rnd_reg[RND_W-1]} - {1'b0, ties_reg};

    always_comb
    begin
        sat_next = sat_reg;
        for (int j = 0; j < MAX_CHUNKS; j++)
        begin
            cnt_next[j] = cnt_reg[j];
        end
        priority if (cmd.emit)
        begin
            for (int j = 0; j < MAX_CHUNKS; j++)
            begin
                cnt_next[j] = '0;
            end
            sat_next = 1'b0;
        end
        else if (cmd.count_row)
        begin
            for (int j = 0; j < MAX_CHUNKS; j++)
            begin
                if (has_peer && chunk_bits[j] && (CHUNK_CNT_W'(j) < n_active))
                begin
                    if (cnt_reg[j] == COUNT_MAX)
                        sat_next = 1'b1;
                    else
                        cnt_next[j] = cnt_reg[j] + COUNT_WIDTH'(1);
                end
            end
        end
        else if (cmd.min_step || cmd.pick_step)
        begin
            for (int j = 0; j < MAX_CHUNKS - 1; j++)
            begin
                cnt_next[j] = cnt_reg[j+1];
            end
            cnt_next[MAX_CHUNKS-1] = cnt_reg[0];
        end
        else
        begin
            sat_next = sat_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < MAX_CHUNKS; j++)
            begin
                cnt_reg[j] <= '0;
            end
            sat_reg <= 1'b0;
            idx_reg <= '0;
        end
        else
        begin
            for (int j = 0; j < MAX_CHUNKS; j++)
            begin
                cnt_reg[j] <= cnt_next[j];
            end
            sat_reg <= sat_next;
            if (cmd.start)
                idx_reg <= '0;
            else if (cmd.min_step || cmd.pick_step)
                idx_reg <= status.idx_last ? '0 : idx_reg + IDX_W'(1);
        end
    end

    // scan, remainder and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            min_reg  <= COUNT_MAX;
            ties_reg <= '0;
            rnd_reg  <= random_word;
        end
        if (cmd.min_step && head_active)
        begin
            if (cnt_reg[0] < min_reg)
            begin
                min_reg  <= cnt_reg[0];
                ties_reg <= CHUNK_CNT_W'(1);
            end
            else if (cnt_reg[0] == min_reg)
            begin
                ties_reg <= ties_reg + CHUNK_CNT_W'(1);
            end
        end
        if (cmd.div_load)
        begin
            rem_reg     <= '0;
            bit_cnt_reg <= RND_CNT_W'(RND_W - 1);
            seen_reg    <= '0;
            found_reg   <= 1'b0;
            sel_reg     <= '0;
        end
        if (cmd.div_step)
        begin
            if (!trial[CHUNK_CNT_W])
                rem_reg <= trial[CHUNK_CNT_W-1:0];
            else
                rem_reg <= {rem_reg[CHUNK_CNT_W-2:0], rnd_reg[RND_W-1]};
            rnd_reg     <= {rnd_reg[RND_W-2:0], 1'b0};
            bit_cnt_reg <= bit_cnt_reg - RND_CNT_W'(1);
        end
        if (cmd.pick_step && head_is_min && !found_reg)
        begin
            if (seen_reg == rem_reg)
            begin
                sel_reg   <= idx_reg;
                found_reg <= 1'b1;
            end
            else
            begin
                seen_reg <= seen_reg + CHUNK_CNT_W'(1);
            end
        end
        if (cmd.emit)
        begin
            chunk_index_reg     <= idx_to_out(sel_reg);
            rarest_count_reg    <= count_to_out(min_reg);
            tie_count_reg       <= tie_to_out(ties_reg);
            count_saturated_reg <= sat_reg;
        end
    end

    assign chunk_index     = chunk_index_reg;
    assign rarest_count    = rarest_count_reg;
    assign tie_count       = tie_count_reg;
    assign count_saturated = count_saturated_reg;

endmodule

### src/rcs_checker.sv
// rcs_checker: port-level assertions for the rarest chunk selector, bound
// to the top level; no package dependency
module rcs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    // a held result stays offered
    a_out_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // a held result keeps its payload
    a_out_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result payload changed while stalled");

    // a final row starts the selection, which takes no row in the next cycle
    a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("row taken during selection");

    // a new result appears only at the end of a selection
    a_result_after_select: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result without selection");

    // at least one and at most all chunks tie
    a_tie_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[22:16] != 7'd0) && (m_axis_tdata[22:16] <= 7'd64))
        else $error("tie count out of range");

endmodule

bind rarest_chunk_selector rcs_checker u_rcs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
